@@ rtl/core/tcgw_pkg.sv @@
// Shared types and constants of the text console glyph writer.
// No dependencies; the files that use it refer to it by scoped names.
package tcgw_pkg;

	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;
	localparam int OFFSET_W = 22;
	localparam int MASK_W   = 6;
	localparam int COLOR_W  = 16;

	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH = 3'd0,
		REG_TEXT_COLUMNS = 3'd1,
		REG_TEXT_ROWS    = 3'd2,
		REG_DRAW_COLOR   = 3'd3,
		REG_HIGH_CODES   = 3'd4
	} reg_idx_t;

	localparam logic       CMD_PUT      = 1'b0;
	localparam logic       CMD_LOAD     = 1'b1;
	localparam logic [7:0] CODE_NEWLINE = 8'h0A;
	localparam logic [7:0] CODE_HIGH    = 8'h80;

	localparam logic [11:0] RST_SCREEN_WIDTH = 12'd800;
	localparam logic [7:0]  RST_TEXT_COLUMNS = 8'd133;
	localparam logic [7:0]  RST_TEXT_ROWS    = 8'd60;
	localparam logic [15:0] RST_DRAW_COLOR   = 16'd32767;
	localparam logic        RST_HIGH_CODES   = 1'b1;

	typedef struct packed {
		logic [11:0] screen_width;
		logic [7:0]  text_columns;
		logic [7:0]  text_rows;
		logic [15:0] draw_color;
		logic        high_codes;
	} cfg_t;

	// one accepted item, decoded against the cursor
	typedef struct packed {
		logic       draw;   // start a draw or error job
		logic       err;    // cursor out of range
		logic       load;   // glyph row load
		logic [7:0] code;
		logic [7:0] row;
		logic [7:0] col;
		logic [2:0] grow;
		logic [5:0] bits;
	} disp_t;

endpackage

@@ rtl/core/tcgw_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on tcgw_pkg for payload widths.
interface tcgw_item_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] char_code;
	logic [2:0] glyph_row;
	logic [5:0] glyph_bits;

	modport source (output valid, command, char_code, glyph_row, glyph_bits, input ready);
	modport sink   (input valid, command, char_code, glyph_row, glyph_bits, output ready);
endinterface

interface tcgw_result_if;
	logic                          valid;
	logic                          ready;
	logic [tcgw_pkg::OFFSET_W-1:0] pixel_offset;
	logic [tcgw_pkg::MASK_W-1:0]   pixel_mask;
	logic [tcgw_pkg::COLOR_W-1:0]  pixel_color;
	logic                          cursor_error;
	logic                          last_row;

	modport source (output valid, pixel_offset, pixel_mask, pixel_color, cursor_error,
		last_row, input ready);
	modport sink   (input valid, pixel_offset, pixel_mask, pixel_color, cursor_error,
		last_row, output ready);
endinterface

@@ rtl/core/tcgw_regs.sv @@
// APB configuration registers of the glyph writer.
// Depends on tcgw_pkg (cfg_t, register indexes).
module tcgw_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcgw_pkg::APB_AW-1:0] paddr,
	input  logic [tcgw_pkg::APB_DW-1:0] pwdata,
	output logic [tcgw_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output tcgw_pkg::cfg_t              cfg
);

	tcgw_pkg::cfg_t     cfg_q;
	tcgw_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = tcgw_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width <= tcgw_pkg::RST_SCREEN_WIDTH;
			cfg_q.text_columns <= tcgw_pkg::RST_TEXT_COLUMNS;
			cfg_q.text_rows    <= tcgw_pkg::RST_TEXT_ROWS;
			cfg_q.draw_color   <= tcgw_pkg::RST_DRAW_COLOR;
			cfg_q.high_codes   <= tcgw_pkg::RST_HIGH_CODES;
		end else if (wr_en) begin
			case (idx)
				tcgw_pkg::REG_SCREEN_WIDTH: cfg_q.screen_width <= pwdata[11:0];
				tcgw_pkg::REG_TEXT_COLUMNS: cfg_q.text_columns <= pwdata[7:0];
				tcgw_pkg::REG_TEXT_ROWS:    cfg_q.text_rows    <= pwdata[7:0];
				tcgw_pkg::REG_DRAW_COLOR:   cfg_q.draw_color   <= pwdata[15:0];
				tcgw_pkg::REG_HIGH_CODES:   cfg_q.high_codes   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tcgw_pkg::REG_SCREEN_WIDTH: prdata = {20'd0, cfg_q.screen_width};
			tcgw_pkg::REG_TEXT_COLUMNS: prdata = {24'd0, cfg_q.text_columns};
			tcgw_pkg::REG_TEXT_ROWS:    prdata = {24'd0, cfg_q.text_rows};
			tcgw_pkg::REG_DRAW_COLOR:   prdata = {16'd0, cfg_q.draw_color};
			tcgw_pkg::REG_HIGH_CODES:   prdata = {31'd0, cfg_q.high_codes};
			default:                    prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/tcgw_cursor.sv @@
// Text cursor registers and item decode of the glyph writer.
// Depends on tcgw_pkg (cfg_t, disp_t, character codes).
module tcgw_cursor (
	input  logic            clk,
	input  logic            arst_n,
	input  tcgw_pkg::cfg_t  cfg,
	input  logic            accept,
	input  logic            command,
	input  logic [7:0]      char_code,
	input  logic [2:0]      glyph_row,
	input  logic [5:0]      glyph_bits,
	output tcgw_pkg::disp_t disp
);

	logic [7:0] col_q, row_q, col_d, row_d;
	logic [7:0] col_inc, nl_row;
	logic       in_range, is_nl, is_put, drawable;

	assign in_range = (col_q < cfg.text_columns) && (row_q < cfg.text_rows);
	assign is_nl    = (char_code == tcgw_pkg::CODE_NEWLINE);
	assign is_put   = accept && (command == tcgw_pkg::CMD_PUT);
	assign col_inc  = col_q + 8'd1;
	// no scrolling: the row sticks on the last line
	assign nl_row   = (({1'b0, row_q} + 9'd1) < {1'b0, cfg.text_rows}) ? row_q + 8'd1
		: row_q;
	assign drawable = !(((char_code & tcgw_pkg::CODE_HIGH) != 8'd0) && !cfg.high_codes);

	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (is_put) begin
			if (is_nl || (col_inc >= cfg.text_columns)) begin
				col_d = 8'd0;
				row_d = nl_row;
			end else begin
				col_d = col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 8'd0;
			row_q <= 8'd0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	always_comb begin
		disp.draw = is_put && !is_nl && (!in_range || drawable);
		disp.err  = !in_range;
		disp.load = accept && (command == tcgw_pkg::CMD_LOAD);
		disp.code = char_code;
		disp.row  = row_q;
		disp.col  = col_q;
		disp.grow = glyph_row;
		disp.bits = glyph_bits;
	end

endmodule

@@ rtl/core/tcgw_glyph_ram.sv @@
// Glyph store: one write port, one read port, registered read data.
// No dependencies.
module tcgw_glyph_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [5:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [5:0]    rdata
);

	logic [5:0] mem [DEPTH];

	// read before write on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/tcgw_draw.sv @@
// Draw engine: glyph row sequencer, glyph store and result stage.
// Depends on tcgw_pkg, tcgw_if (result channel) and tcgw_glyph_ram.
module tcgw_draw #(
	parameter int GLYPH_WIDTH  = 6,
	parameter int GLYPH_HEIGHT = 8,
	parameter int GLYPH_COUNT  = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tcgw_pkg::cfg_t  cfg,
	input  tcgw_pkg::disp_t disp,
	output logic            slot_free,
	tcgw_result_if.source   result
);

	localparam int DEPTH   = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int AW      = $clog2(DEPTH);
	localparam int RW      = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
	localparam int LINE_W  = $clog2(256 * GLYPH_HEIGHT);
	localparam int COLPX_W = $clog2(256 * GLYPH_WIDTH);
	localparam int PROD_W  = LINE_W + 12;
	localparam int SUM_W   = (PROD_W + 1 > tcgw_pkg::OFFSET_W) ? PROD_W + 1 : tcgw_pkg::OFFSET_W;
	localparam logic [5:0] MASK_ALL = (GLYPH_WIDTH >= 6) ? 6'h3F : 6'((1 << GLYPH_WIDTH) - 1);

	logic [7:0]         code_mod;
	logic [AW-1:0]      base_d, waddr, raddr;
	logic               we, re;
	logic [5:0]         rdata;

	logic               job_busy_q, job_err_q;
	logic [AW-1:0]      job_base_q;
	logic [LINE_W-1:0]  job_line_q, line_sum;
	logic [COLPX_W-1:0] job_colpx_q;
	logic [RW-1:0]      job_r_q;
	logic               job_last, advance, issue;

	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   sum;

	logic                          s1_valid_q, s1_err_s1, s1_last_s1;
	logic [tcgw_pkg::OFFSET_W-1:0] off_s1;

	// glyph index modulo the store size; code is below twice the count
	assign code_mod = ({1'b0, disp.code} >= 9'(GLYPH_COUNT)) ? disp.code - 8'(GLYPH_COUNT)
		: disp.code;
	assign base_d   = AW'(32'(code_mod) * GLYPH_HEIGHT);
	assign we       = disp.load && (32'(disp.grow) < GLYPH_HEIGHT);
	assign waddr    = base_d + AW'(disp.grow);

	assign advance   = !s1_valid_q || result.ready;
	assign job_last  = job_err_q || (job_r_q == RW'(GLYPH_HEIGHT - 1));
	assign issue     = advance && job_busy_q;
	assign slot_free = !job_busy_q || (advance && job_last);
	assign re        = issue && !job_err_q;
	assign raddr     = job_base_q + AW'(job_r_q);

	assign line_sum = job_line_q + LINE_W'(job_r_q);
	assign prod     = PROD_W'(line_sum) * PROD_W'(cfg.screen_width);
	assign sum      = SUM_W'(prod) + SUM_W'(job_colpx_q);

	tcgw_glyph_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (disp.bits),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_busy_q <= 1'b0;
			job_r_q    <= '0;
		end else if (disp.draw) begin
			job_busy_q <= 1'b1;
			job_r_q    <= '0;
		end else if (issue) begin
			if (job_last) begin
				job_busy_q <= 1'b0;
			end else begin
				job_r_q <= job_r_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (disp.draw) begin
			job_err_q   <= disp.err;
			job_base_q  <= base_d;
			job_line_q  <= LINE_W'(32'(disp.row) * GLYPH_HEIGHT);
			job_colpx_q <= COLPX_W'(32'(disp.col) * GLYPH_WIDTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_err_s1  <= job_err_q;
			s1_last_s1 <= job_last;
			off_s1     <= sum[tcgw_pkg::OFFSET_W-1:0];
		end
	end

	assign result.valid        = s1_valid_q;
	assign result.pixel_offset = s1_err_s1 ? '0 : off_s1;
	assign result.pixel_mask   = s1_err_s1 ? '0 : (rdata & MASK_ALL);
	assign result.pixel_color  = s1_err_s1 ? '0 : cfg.draw_color;
	assign result.cursor_error = s1_err_s1;
	assign result.last_row     = s1_last_s1;

endmodule

@@ rtl/core/text_console_glyph_writer_top.sv @@
// Top level of the text console glyph writer.
// Depends on tcgw_pkg, tcgw_if, tcgw_regs, tcgw_cursor and tcgw_draw.
//
// A printable character gives GLYPH_HEIGHT row writes (8 by default): the draw
// engine does one glyph store read and hands out one row write per cycle while
// the result is not stalled, and the next item is taken in the cycle the last
// row of the current character is read. A cursor error gives one result. A load
// is written to the glyph store at once; glyph rows must be loaded before a
// character that uses them is drawn, and the store has no clearing pass. A
// stalled result holds the engine but not configuration writes.
module text_console_glyph_writer_top #(
	parameter int GLYPH_WIDTH  = 6,
	parameter int GLYPH_HEIGHT = 8,
	parameter int GLYPH_COUNT  = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcgw_pkg::APB_AW-1:0] paddr,
	input  logic [tcgw_pkg::APB_DW-1:0] pwdata,
	output logic [tcgw_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	tcgw_item_if.sink                   item,
	tcgw_result_if.source               result
);

	tcgw_pkg::cfg_t  cfg;
	tcgw_pkg::disp_t disp;
	logic            slot_free;
	logic            accept;

	assign item.ready = slot_free;
	assign accept     = item.valid && slot_free;

	tcgw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcgw_cursor u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.command    (item.command),
		.char_code  (item.char_code),
		.glyph_row  (item.glyph_row),
		.glyph_bits (item.glyph_bits),
		.disp       (disp)
	);

	tcgw_draw #(
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.GLYPH_COUNT  (GLYPH_COUNT)
	) u_draw (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.disp      (disp),
		.slot_free (slot_free),
		.result    (result)
	);

endmodule

@@ rtl/core/tcgw_checker.sv @@
// Port-level checks of the glyph writer, bound to the top level.
// Depends on tcgw_pkg and tcgw_if.
module tcgw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [tcgw_pkg::APB_AW-1:0] paddr,
	input logic [tcgw_pkg::APB_DW-1:0] pwdata,
	input logic [tcgw_pkg::APB_DW-1:0] prdata,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [tcgw_pkg::OFFSET_W-1:0] res_offset,
	input logic [tcgw_pkg::MASK_W-1:0]   res_mask,
	input logic [tcgw_pkg::COLOR_W-1:0]  res_color,
	input logic                        res_error,
	input logic                        res_last
);

	// a stalled result transaction stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_offset) && $stable(res_mask)
			&& $stable(res_error) && $stable(res_last))
		else $error("result payload changed while stalled");

	// an error result is a lone, empty transaction
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_error |-> res_last && (res_mask == '0) && (res_offset == '0)
			&& (res_color == '0))
		else $error("malformed cursor error result");

	// screen width reads back what was written just before
	a_width_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[4:2] == tcgw_pkg::REG_SCREEN_WIDTH))
		##1 (psel && !pwrite && (paddr[4:2] == tcgw_pkg::REG_SCREEN_WIDTH))
		|-> (prdata[11:0] == $past(pwdata[11:0])))
		else $error("screen width readback mismatch");

endmodule

bind text_console_glyph_writer_top tcgw_checker u_tcgw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_offset (result.pixel_offset),
	.res_mask   (result.pixel_mask),
	.res_color  (result.pixel_color),
	.res_error  (result.cursor_error),
	.res_last   (result.last_row)
);

@@ tb/glyph_writer_monitor.sv @@
`timescale 1ns / 100ps
// Checker for the text console glyph writer: follows register writes and item
// transactions, predicts every pixel row write and compares results in order.
// Depends on tcgw_pkg and the channel interfaces in tcgw_if.
module glyph_writer_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [tcgw_pkg::APB_AW-1:0] paddr,
	input  logic [tcgw_pkg::APB_DW-1:0] pwdata,
	tcgw_item_if                        item,
	tcgw_result_if                      result,
	output int                          mismatches,
	output int                          writes_due
);

	localparam int GLYPH_W = 6;
	localparam int GLYPH_H = 8;

	typedef struct packed {
		logic [tcgw_pkg::OFFSET_W-1:0] offset;
		logic [tcgw_pkg::MASK_W-1:0]   mask;
		logic [tcgw_pkg::COLOR_W-1:0]  color;
		logic                          err;
		logic                          last;
	} row_write_t;

	tcgw_pkg::cfg_t cfg;
	logic [7:0]     cur_col;
	logic [7:0]     cur_row;
	logic [5:0]     glyph_mem [0:2047];
	row_write_t     expected_rows [$];
	row_write_t     seen;
	row_write_t     want;
	int             errors;

	// no scrolling: the row sticks on the last text line
	function automatic void line_feed();
		cur_col = '0;
		if ({1'b0, cur_row} + 9'd1 < {1'b0, cfg.text_rows})
			cur_row = cur_row + 8'd1;
	endfunction

	function automatic void predict_rows(input logic cmd, input logic [7:0] code,
			input logic [2:0] grow, input logic [5:0] bits);
		row_write_t  w;
		logic [31:0] off;
		if (cmd == tcgw_pkg::CMD_LOAD) begin
			glyph_mem[{code, grow}] = bits;
			return;
		end
		if (code == tcgw_pkg::CODE_NEWLINE) begin
			line_feed();
			return;
		end
		if (cur_col >= cfg.text_columns || cur_row >= cfg.text_rows) begin
			w = '0;
			w.err = 1'b1;
			w.last = 1'b1;
			expected_rows.push_back(w);
		end else if (!((code & tcgw_pkg::CODE_HIGH) != 8'h00 && !cfg.high_codes)) begin
			for (int r = 0; r < GLYPH_H; r++) begin
				off = (int'(cur_row) * GLYPH_H + r) * int'(cfg.screen_width)
					+ int'(cur_col) * GLYPH_W;
				w.offset = off[tcgw_pkg::OFFSET_W-1:0];
				w.mask   = glyph_mem[{code, 3'(r)}];
				w.color  = cfg.draw_color;
				w.err    = 1'b0;
				w.last   = (r == GLYPH_H - 1);
				expected_rows.push_back(w);
			end
		end
		cur_col = cur_col + 8'd1;
		if (cur_col >= cfg.text_columns)
			line_feed();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.screen_width = tcgw_pkg::RST_SCREEN_WIDTH;
			cfg.text_columns = tcgw_pkg::RST_TEXT_COLUMNS;
			cfg.text_rows    = tcgw_pkg::RST_TEXT_ROWS;
			cfg.draw_color   = tcgw_pkg::RST_DRAW_COLOR;
			cfg.high_codes   = tcgw_pkg::RST_HIGH_CODES;
			cur_col = '0;
			cur_row = '0;
			expected_rows.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (tcgw_pkg::reg_idx_t'(paddr[tcgw_pkg::APB_AW-1:2]))
				tcgw_pkg::REG_SCREEN_WIDTH: cfg.screen_width = pwdata[11:0];
				tcgw_pkg::REG_TEXT_COLUMNS: cfg.text_columns = pwdata[7:0];
				tcgw_pkg::REG_TEXT_ROWS:    cfg.text_rows    = pwdata[7:0];
				tcgw_pkg::REG_DRAW_COLOR:   cfg.draw_color   = pwdata[15:0];
				tcgw_pkg::REG_HIGH_CODES:   cfg.high_codes   = pwdata[0];
				default: ;
				endcase
			end
			// item first: a result in the same cycle can only belong to older items
			if (item.valid && item.ready)
				predict_rows(item.command, item.char_code, item.glyph_row, item.glyph_bits);
			if (result.valid && result.ready) begin
				seen.offset = result.pixel_offset;
				seen.mask   = result.pixel_mask;
				seen.color  = result.pixel_color;
				seen.err    = result.cursor_error;
				seen.last   = result.last_row;
				if (expected_rows.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$write("%0t unexpected row write: offset %0d ", $time, seen.offset);
						$display("mask %h color %h err %b last %b",
							seen.mask, seen.color, seen.err, seen.last);
					end
				end else begin
					want = expected_rows.pop_front();
					if (seen.offset !== want.offset || seen.mask !== want.mask
							|| seen.color !== want.color || seen.err !== want.err
							|| seen.last !== want.last) begin
						errors++;
						if (errors <= 10) begin
							$write("%0t row write mismatch (exp/got): offset %0d/%0d ",
								$time, want.offset, seen.offset);
							$display("mask %h/%h color %h/%h err %b/%b last %b/%b",
								want.mask, seen.mask, want.color, seen.color,
								want.err, seen.err, want.last, seen.last);
						end
					end
				end
			end
		end
		mismatches <= errors;
		writes_due <= expected_rows.size();
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the glyph writer testbench: clock, reset, register phases, item and
// result-ready stimulus, verdict. Depends on tcgw_pkg, tcgw_if, the block
// and glyph_writer_monitor.
module testbench;

	localparam int LIMIT = 300000;
	localparam int DRAIN = 32;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic                        pready;
	logic [tcgw_pkg::APB_AW-1:0] paddr;
	logic [tcgw_pkg::APB_DW-1:0] pwdata;
	logic [tcgw_pkg::APB_DW-1:0] prdata;
	int                          cycles;
	int                          mismatches;
	int                          writes_due;
	int                          ready_hold;
	bit                          no_idle;
	logic [7:0]                  glyph_loaded [256] = '{default: '0};
	logic [7:0]                  drawable_codes [$];

	tcgw_item_if   item_ch();
	tcgw_result_if result_ch();

	text_console_glyph_writer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	glyph_writer_monitor mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.item       (item_ch),
		.result     (result_ch),
		.mismatches (mismatches),
		.writes_due (writes_due)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// mostly short stalls, a few long ones
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			result_ch.ready <= 1'b0;
			ready_hold <= idle_len() - 1;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic send_item(input logic cmd, input logic [7:0] code,
			input logic [2:0] grow, input logic [5:0] bits);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 3) == 0)
			gap = idle_len();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.command    <= cmd;
		item_ch.char_code  <= code;
		item_ch.glyph_row  <= grow;
		item_ch.glyph_bits <= bits;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task automatic load_row(input logic [7:0] code, input logic [2:0] grow,
			input logic [5:0] bits);
		send_item(tcgw_pkg::CMD_LOAD, code, grow, bits);
		if (glyph_loaded[code] != 8'hFF) begin
			glyph_loaded[code][grow] = 1'b1;
			if (glyph_loaded[code] == 8'hFF)
				drawable_codes.push_back(code);
		end
	endtask

	// never draws a glyph row that was not loaded
	task automatic put_char(input logic [7:0] code);
		if (code != tcgw_pkg::CODE_NEWLINE)
			for (int r = 0; r < 8; r++)
				if (!glyph_loaded[code][r])
					load_row(code, 3'(r), 6'($urandom_range(0, 63)));
		send_item(tcgw_pkg::CMD_PUT, code, 3'($urandom_range(0, 7)),
			6'($urandom_range(0, 63)));
	endtask

	// fresh codes are rare: each one costs a full glyph load
	task automatic random_item();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10)
			load_row(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
				6'($urandom_range(0, 63)));
		else if (p < 30)
			put_char(tcgw_pkg::CODE_NEWLINE);
		else if (p < 92 && drawable_codes.size() > 0)
			put_char(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]);
		else
			put_char(8'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(input tcgw_pkg::reg_idx_t idx,
			input logic [tcgw_pkg::APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [11:0] width, input logic [7:0] cols,
			input logic [7:0] rows, input logic [15:0] color, input logic high);
		write_reg(tcgw_pkg::REG_SCREEN_WIDTH, 32'(width));
		write_reg(tcgw_pkg::REG_TEXT_COLUMNS, 32'(cols));
		write_reg(tcgw_pkg::REG_TEXT_ROWS, 32'(rows));
		write_reg(tcgw_pkg::REG_DRAW_COLOR, 32'(color));
		write_reg(tcgw_pkg::REG_HIGH_CODES, 32'(high));
	endtask

	// all rows delivered, then room for trailing loads and newlines
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (writes_due != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	initial begin
		item_ch.valid      <= 1'b0;
		item_ch.command    <= tcgw_pkg::CMD_PUT;
		item_ch.char_code  <= '0;
		item_ch.glyph_row  <= '0;
		item_ch.glyph_bits <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		arst_n  <= 1'b0;
		no_idle = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme masks, extreme codes, newline
		configure(12'd800, 8'd133, 8'd60, 16'hFFFF, 1'b1);
		for (int r = 0; r < 8; r++) begin
			load_row(8'h00, 3'(r), r[0] ? 6'h00 : 6'h3F);
			load_row(8'hFF, 3'(r), r[0] ? 6'h15 : 6'h2A);
		end
		put_char(8'h00);
		put_char(8'hFF);
		put_char(tcgw_pkg::CODE_NEWLINE);
		put_char(8'hFF);
		load_row(8'h00, 3'd7, 6'h21);
		put_char(8'h00);
		settle();

		// column past the end, high codes skipped, wrap on the last line
		configure(12'd1, 8'd2, 8'd2, 16'h0000, 1'b0);
		put_char(8'h41);
		put_char(8'h80);
		put_char(8'h7F);
		repeat (10) random_item();
		settle();

		// row past the end: every drawable code errors
		no_idle = 1'b1;
		configure(12'd2048, 8'd1, 8'd1, 16'h8001, 1'b1);
		repeat (6) random_item();
		settle();

		// zero sized text area
		no_idle = 1'b0;
		configure(12'd0, 8'd0, 8'd0, 16'($urandom_range(0, 65535)), 1'b1);
		put_char(8'h41);
		repeat (5) random_item();
		settle();

		for (int k = 0; k < 3; k++) begin
			no_idle = (k == 1);
			configure(12'($urandom_range(1, 2048)), 8'($urandom_range(1, 255)),
				8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)));
			repeat (6) random_item();
			settle();
		end

		// maximum geometry, a few lines down
		no_idle = 1'b0;
		configure(12'd4095, 8'd255, 8'd255, 16'($urandom_range(0, 65535)), 1'b1);
		repeat (8) put_char(tcgw_pkg::CODE_NEWLINE);
		put_char(8'hFF);
		repeat (6) random_item();
		settle();

		if (mismatches == 0 && writes_due == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
